@@ hdl/idl_pkg.sv @@
package idl_pkg;

	localparam int WORD_W      = 32;
	localparam int POS_W       = 6;
	localparam int REQ_W       = 2;
	localparam int STATUS_W    = 2;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_TUSER_W = 2;

	localparam logic [REQ_W-1:0] REQ_INS_FRONT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_INS_BACK  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DELETE    = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic capture;
		logic exec;
		logic shift_rd;
		logic shift_wr;
		logic shift_done;
		logic list_rd;
		logic list_next;
	} idl_cmd_t;

	typedef struct packed {
		logic del_ok;
		logic shift_more;
		logic last;
	} idl_sts_t;

endpackage

@@ hdl/idl_ctrl.sv @@
module idl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  idl_pkg::idl_sts_t   sts,
	output idl_pkg::idl_cmd_t   cmd
);

	typedef enum logic [2:0] {
		IDLE,
		EXEC,
		SHIFT_RD,
		SHIFT_WR,
		LIST_RD,
		LIST_OUT
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   in_ready_q;
	logic   out_valid_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = EXEC;
				end
			end
			EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = sts.del_ok ? SHIFT_RD : LIST_RD;
			end
			SHIFT_RD: begin
				if (sts.shift_more) begin
					cmd.shift_rd = 1'b1;
					state_nxt    = SHIFT_WR;
				end else begin
					cmd.shift_done = 1'b1;
					state_nxt      = LIST_RD;
				end
			end
			SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				state_nxt    = SHIFT_RD;
			end
			LIST_RD: begin
				cmd.list_rd = 1'b1;
				state_nxt   = LIST_OUT;
			end
			LIST_OUT: begin
				if (out_ready) begin
					cmd.list_next = 1'b1;
					state_nxt     = sts.last ? IDLE : LIST_RD;
				end
			end
			default: begin
				state_nxt = IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			in_ready_q  <= (state_nxt == IDLE);
			out_valid_q <= (state_nxt == LIST_OUT);
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

endmodule

@@ hdl/idl_dp.sv @@
module idl_dp #(
	parameter int CAPACITY = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  idl_pkg::idl_cmd_t                   cmd,
	output idl_pkg::idl_sts_t                   sts,
	input  logic [idl_pkg::REQ_W-1:0]           in_type,
	input  logic signed [idl_pkg::WORD_W-1:0]   in_value,
	input  logic [idl_pkg::POS_W-1:0]           in_pos,
	output logic                                out_dir,
	output logic signed [idl_pkg::WORD_W-1:0]   out_element,
	output logic                                out_present,
	output logic [idl_pkg::STATUS_W-1:0]        out_status,
	output logic                                out_last
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = CW + 1;
	localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [AW-1:0] TOP_A = AW'(CAPACITY - 1);

	logic [idl_pkg::WORD_W-1:0] mem_q [CAPACITY];

	logic [AW-1:0]                head_q;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                idx_q;
	logic                         dir_q;
	logic [idl_pkg::REQ_W-1:0]    type_q;
	logic [idl_pkg::WORD_W-1:0]   value_q;
	logic [idl_pkg::POS_W-1:0]    pos_q;
	logic [idl_pkg::STATUS_W-1:0] status_q;
	logic [idl_pkg::WORD_W-1:0]   rd_data_q;
	logic                         present_q;
	logic                         last_q;

	logic                         is_push;
	logic                         push_ok;
	logic                         del_ok;
	logic [AW-1:0]                head_dec;
	logic [CW-1:0]                idx_inc;
	logic [CW-1:0]                n_last;
	logic [CW-1:0]                list_idx;
	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	logic [idl_pkg::WORD_W-1:0]   wr_data;
	logic                         rd_en;
	logic [AW-1:0]                rd_addr;

	// Logical position to physical slot of the circular store.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
		logic [SW-1:0] s;
		s = SW'(h) + SW'(l);
		if (s >= CAP_S) begin
			s = s - CAP_S;
		end
		return AW'(s);
	endfunction

	assign is_push  = (type_q == idl_pkg::REQ_INS_FRONT) || (type_q == idl_pkg::REQ_INS_BACK);
	assign push_ok  = is_push && (count_q != CAP_C);
	assign del_ok   = (type_q == idl_pkg::REQ_DELETE) && (pos_q < idl_pkg::POS_W'(count_q));
	assign head_dec = (head_q == '0) ? TOP_A : head_q - 1'b1;
	assign idx_inc  = idx_q + 1'b1;
	assign n_last   = (count_q == '0) ? '0 : count_q - 1'b1;
	assign list_idx = (count_q == '0) ? '0 : (dir_q ? n_last - idx_q : idx_q);

	assign sts.del_ok     = del_ok;
	assign sts.shift_more = (SW'(idx_q) + SW'(1)) < SW'(count_q);
	assign sts.last       = last_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = phys(head_q, idx_q);
		wr_data = rd_data_q;
		if (cmd.exec && push_ok) begin
			wr_en   = 1'b1;
			wr_data = value_q;
			if (type_q == idl_pkg::REQ_INS_FRONT) begin
				wr_addr = head_dec;
			end else begin
				wr_addr = phys(head_q, count_q);
			end
		end else if (cmd.shift_wr) begin
			wr_en = 1'b1;
		end
	end

	assign rd_en   = cmd.shift_rd || cmd.list_rd;
	assign rd_addr = cmd.shift_rd ? phys(head_q, idx_inc) : phys(head_q, list_idx);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			type_q  <= in_type;
			value_q <= in_value;
			pos_q   <= in_pos;
		end
		if (cmd.exec) begin
			if (is_push && !push_ok) begin
				status_q <= idl_pkg::ST_FULL;
			end else if ((type_q == idl_pkg::REQ_DELETE) && !del_ok) begin
				status_q <= idl_pkg::ST_RANGE;
			end else begin
				status_q <= idl_pkg::ST_DONE;
			end
		end
		if (cmd.list_rd) begin
			present_q <= (count_q != '0);
			last_q    <= dir_q && (idx_q == n_last);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			dir_q   <= 1'b0;
		end else begin
			if (cmd.exec) begin
				dir_q <= 1'b0;
				idx_q <= del_ok ? CW'(pos_q) : '0;
				if (push_ok) begin
					count_q <= count_q + 1'b1;
					if (type_q == idl_pkg::REQ_INS_FRONT) begin
						head_q <= head_dec;
					end
				end
			end
			if (cmd.shift_wr) begin
				idx_q <= idx_inc;
			end
			if (cmd.shift_done) begin
				count_q <= count_q - 1'b1;
				idx_q   <= '0;
				dir_q   <= 1'b0;
			end
			if (cmd.list_next) begin
				if (idx_q == n_last) begin
					idx_q <= '0;
					dir_q <= 1'b1;
				end else begin
					idx_q <= idx_inc;
				end
			end
		end
	end

	assign out_dir     = dir_q;
	assign out_element = present_q ? rd_data_q : '0;
	assign out_present = present_q;
	assign out_status  = status_q;
	assign out_last    = last_q;

endmodule

@@ hdl/indexed_deque_with_listing_unit.sv @@
// Channel  Dir  Handshake           Payload
// s        in   s_tvalid/s_tready   tuser: req_type; tdata: value, position
// m        out  m_tvalid/m_tready   tuser: direction, present; tdata: element, status; tlast
//
// A request is taken only when the unit is idle; it is captured, then applied in EXEC.
// A delete then moves each later entry down one place, reading it in SHIFT_RD and
// writing it in SHIFT_WR, and lowers the count in a last SHIFT_RD to finish.
// Every listed result is read through the single read port of the store in LIST_RD
// and offered in LIST_OUT; each entry is listed forward, then in reverse order.
// Reset clears the count and the front pointer; the store itself is not cleared.
// A stalled result holds on m until taken, and no new request is taken meanwhile.
module indexed_deque_with_listing_unit #(
	parameter int CAPACITY = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [idl_pkg::IN_TDATA_W-1:0]       s_tdata,   // value, position
	input  logic [idl_pkg::REQ_W-1:0]            s_tuser,   // req_type
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [idl_pkg::OUT_TDATA_W-1:0]      m_tdata,   // element, status
	output logic [idl_pkg::OUT_TUSER_W-1:0]      m_tuser,   // direction, present
	output logic                                 m_tlast
);

	idl_pkg::idl_cmd_t                 cmd;
	idl_pkg::idl_sts_t                 sts;
	logic                              out_dir;
	logic signed [idl_pkg::WORD_W-1:0] out_element;
	logic                              out_present;
	logic [idl_pkg::STATUS_W-1:0]      out_status;

	idl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	idl_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_type     (s_tuser),
		.in_value    (s_tdata[idl_pkg::WORD_W-1:0]),
		.in_pos      (s_tdata[idl_pkg::WORD_W +: idl_pkg::POS_W]),
		.out_dir     (out_dir),
		.out_element (out_element),
		.out_present (out_present),
		.out_status  (out_status),
		.out_last    (m_tlast)
	);

	assign m_tdata = idl_pkg::OUT_TDATA_W'({out_status, out_element});
	assign m_tuser = {out_present, out_dir};

endmodule

@@ hdl/idl_checker.sv @@
module idl_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tready,
	input logic [idl_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input logic [idl_pkg::OUT_TUSER_W-1:0]  m_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic                             m_tlast
);

	localparam int SL = idl_pkg::WORD_W;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("Result changed while stalled.");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("Request taken while a result is pending.");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> m_tdata[SL-1:0] == '0)
		else $error("Empty listing carries a non-zero element.");

	a_fwd_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> !m_tlast)
		else $error("Forward listing marked as final item.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[SL +: idl_pkg::STATUS_W] == idl_pkg::ST_DONE
			|| m_tdata[SL +: idl_pkg::STATUS_W] == idl_pkg::ST_RANGE
			|| m_tdata[SL +: idl_pkg::STATUS_W] == idl_pkg::ST_FULL)
		else $error("Unknown status code.");

endmodule

bind indexed_deque_with_listing_unit idl_checker u_idl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tlast  (m_tlast)
);

@@ tb/tb_top.sv @@
module tb_top;

	localparam int DEPTH = 32;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [idl_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam logic DIR_FORWARD = 1'b0;
	localparam logic DIR_REVERSE = 1'b1;

	typedef struct packed {
		logic                         dir;
		logic [idl_pkg::WORD_W-1:0]   element;
		logic                         present;
		logic [idl_pkg::STATUS_W-1:0] status;
		logic                         last;
	} listing_entry_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [idl_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
	logic [idl_pkg::REQ_W-1:0]       s_tuser = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [idl_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic [idl_pkg::OUT_TUSER_W-1:0] m_tuser;
	logic                            m_tlast;

	logic [idl_pkg::WORD_W-1:0] deque_q[$];
	listing_entry_t             expected_listing[$];
	listing_entry_t             oldest;
	int                         send_idle_pct = 29;
	int                         recv_idle_pct = 69;
	int                         fail_count = 0;
	int                         cycle_count = 0;

	indexed_deque_with_listing_unit #(
		.CAPACITY(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// Applies one request to the list and queues the two listings it produces.
	task automatic predict_listing(input logic [idl_pkg::REQ_W-1:0] req,
			input logic [idl_pkg::WORD_W-1:0] value, input logic [idl_pkg::POS_W-1:0] pos);
		logic [idl_pkg::STATUS_W-1:0] status;
		listing_entry_t               e;
		int                           n;
		status = idl_pkg::ST_DONE;
		if (req == idl_pkg::REQ_INS_FRONT || req == idl_pkg::REQ_INS_BACK) begin
			if (deque_q.size() >= DEPTH)
				status = idl_pkg::ST_FULL;
			else if (req == idl_pkg::REQ_INS_FRONT)
				deque_q = {value, deque_q};
			else
				deque_q = {deque_q, value};
		end else if (req == idl_pkg::REQ_DELETE) begin
			if (pos >= deque_q.size())
				status = idl_pkg::ST_RANGE;
			else
				deque_q.delete(pos);
		end
		n = deque_q.size();
		e.status = status;
		e.last = 1'b0;
		if (n == 0) begin
			e.element = '0;
			e.present = 1'b0;
			e.dir = DIR_FORWARD;
			expected_listing = {expected_listing, e};
			e.dir = DIR_REVERSE;
			e.last = 1'b1;
			expected_listing = {expected_listing, e};
		end else begin
			e.present = 1'b1;
			e.dir = DIR_FORWARD;
			for (int i = 0; i < n; i++) begin
				e.element = deque_q[i];
				expected_listing = {expected_listing, e};
			end
			e.dir = DIR_REVERSE;
			for (int i = n - 1; i >= 0; i--) begin
				e.element = deque_q[i];
				e.last = (i == 0);
				expected_listing = {expected_listing, e};
			end
		end
	endtask

	task automatic send_request(input logic [idl_pkg::REQ_W-1:0] req,
			input logic [idl_pkg::WORD_W-1:0] value, input logic [idl_pkg::POS_W-1:0] pos);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {{(idl_pkg::IN_TDATA_W - idl_pkg::WORD_W - idl_pkg::POS_W){1'b0}}, pos, value};
		do @(posedge clk); while (!s_tready);
		predict_listing(req, value, pos);
	endtask

	task automatic wait_listing_drained();
		s_tvalid <= 1'b0;
		while (expected_listing.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_listing.size() == 0) begin
				$error("unexpected item: element %h", m_tdata[idl_pkg::WORD_W-1:0]);
				fail_count++;
			end else begin
				oldest = expected_listing.pop_front();
				if (m_tuser[0] !== oldest.dir) begin
					$error("direction: expected %0d, got %0d", oldest.dir, m_tuser[0]);
					fail_count++;
				end
				if (m_tdata[idl_pkg::WORD_W-1:0] !== oldest.element) begin
					$error("element: expected %h, got %h", oldest.element,
						m_tdata[idl_pkg::WORD_W-1:0]);
					fail_count++;
				end
				if (m_tuser[1] !== oldest.present) begin
					$error("present: expected %0d, got %0d", oldest.present, m_tuser[1]);
					fail_count++;
				end
				if (m_tdata[idl_pkg::WORD_W +: idl_pkg::STATUS_W] !== oldest.status) begin
					$error("status: expected %0d, got %0d", oldest.status,
						m_tdata[idl_pkg::WORD_W +: idl_pkg::STATUS_W]);
					fail_count++;
				end
				if (m_tlast !== oldest.last) begin
					$error("last: expected %0d, got %0d", oldest.last, m_tlast);
					fail_count++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic logic [idl_pkg::WORD_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_empty_list();
		send_request(idl_pkg::REQ_DELETE, $urandom, 6'd0);
		send_request(idl_pkg::REQ_DELETE, $urandom, 6'd63);
		send_request(REQ_UNUSED, $urandom, 6'($urandom_range(63)));
	endtask

	task automatic test_push_and_delete();
		send_request(idl_pkg::REQ_INS_FRONT, 32'h7FFF_FFFF, 6'd63);
		send_request(idl_pkg::REQ_INS_BACK, 32'h8000_0000, 6'd0);
		send_request(idl_pkg::REQ_INS_FRONT, 32'hFFFF_FFFF, 6'($urandom_range(63)));
		send_request(idl_pkg::REQ_INS_BACK, 32'h0000_0000, 6'($urandom_range(63)));
		send_request(idl_pkg::REQ_INS_FRONT, $urandom, 6'($urandom_range(63)));
		send_request(idl_pkg::REQ_DELETE, $urandom, 6'd2);
		send_request(idl_pkg::REQ_DELETE, $urandom, 6'(deque_q.size()));
		send_request(REQ_UNUSED, 32'hFFFF_FFFF, 6'd63);
		send_request(idl_pkg::REQ_DELETE, $urandom, 6'(deque_q.size() - 1));
		send_request(idl_pkg::REQ_DELETE, $urandom, 6'd0);
		send_request(idl_pkg::REQ_DELETE, $urandom, 6'd63);
		while (deque_q.size() > 0)
			send_request(idl_pkg::REQ_DELETE, $urandom, 6'd0);
	endtask

	// Fill the list to capacity, push against the bound, then trim both ends.
	task automatic test_full_list();
		while (deque_q.size() < DEPTH)
			send_request($urandom_range(1) ? idl_pkg::REQ_INS_BACK : idl_pkg::REQ_INS_FRONT,
				pick_value(), 6'($urandom_range(63)));
		send_request(idl_pkg::REQ_INS_FRONT, $urandom, 6'($urandom_range(63)));
		send_request(idl_pkg::REQ_INS_BACK, $urandom, 6'($urandom_range(63)));
		send_request(idl_pkg::REQ_DELETE, $urandom, 6'd63);
		send_request(idl_pkg::REQ_DELETE, $urandom, 6'd31);
		send_request(idl_pkg::REQ_INS_BACK, 32'h8000_0000, 6'($urandom_range(63)));
		send_request(idl_pkg::REQ_INS_FRONT, $urandom, 6'($urandom_range(63)));
		send_request(idl_pkg::REQ_DELETE, $urandom, 6'd0);
		send_request(idl_pkg::REQ_DELETE, $urandom, 6'd32);
	endtask

	// Runs of pushes or deletes in bursts so that the list swings between empty and full.
	task automatic test_random_requests(input int n);
		int                        push_pct;
		int                        roll;
		logic [idl_pkg::REQ_W-1:0] req;
		logic [idl_pkg::POS_W-1:0] pos;
		push_pct = 50;
		for (int i = 0; i < n; i++) begin
			if (i % 20 == 0) begin
				case ($urandom_range(2))
					0: push_pct = 15;
					1: push_pct = 50;
					default: push_pct = 90;
				endcase
			end
			roll = $urandom_range(99);
			pos = 6'($urandom_range(63));
			if (roll < 4)
				req = REQ_UNUSED;
			else if (roll < 4 + push_pct * 96 / 100)
				req = $urandom_range(1) ? idl_pkg::REQ_INS_BACK : idl_pkg::REQ_INS_FRONT;
			else begin
				req = idl_pkg::REQ_DELETE;
				if (deque_q.size() > 0 && $urandom_range(9) != 0)
					pos = 6'($urandom_range(deque_q.size() - 1));
			end
			send_request(req, pick_value(), pos);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_push_and_delete();
		test_full_list();
		test_random_requests(70);
		wait_listing_drained();
		send_idle_pct = 69;
		recv_idle_pct = 29;
		test_random_requests(70);
		wait_listing_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_requests(35);
		wait_listing_drained();
		test_random_requests(35);
		wait_listing_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/idl_pkg.sv
hdl/idl_ctrl.sv
hdl/idl_dp.sv
hdl/indexed_deque_with_listing_unit.sv
hdl/idl_checker.sv
tb/tb_top.sv
